// ===== hdl/sxf_pkg.sv =====
package sxf_pkg;

  // default screen geometry
  localparam int unsigned DEF_SCREEN_COLUMNS = 64;
  localparam int unsigned DEF_SCREEN_ROWS    = 32;

  // widths fixed by the largest supported screen
  localparam int unsigned PIX_W    = 64;
  localparam int unsigned ROW_W    = 6;
  localparam int unsigned SPRITE_W = 8;

  // request codes on the input channel
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_DRAW  = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  // operations handed from front to back
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_DRAW,
    OP_READ,
    OP_NOP
  } op_e;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_e;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [7:0]          x_pos;
    logic [7:0]          y_pos;
    logic [3:0]          row_offset;
    logic [SPRITE_W-1:0] sprite_bits;
  } in_item_t;

  typedef struct packed {
    logic             collision;
    logic [PIX_W-1:0] row_pixels;
  } out_item_t;

  typedef struct packed {
    op_e              op;
    logic             new_sprite;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] mask;
  } cmd_t;

  // handshake between the command queue and the back end
  typedef struct packed {
    logic   avail;
    cmd_t   cmd;
  } cmdq_out_t;

endpackage

// ===== hdl/sxf_front.sv =====
module sxf_front #(
  parameter int unsigned SCREEN_COLUMNS = sxf_pkg::DEF_SCREEN_COLUMNS,
  parameter int unsigned SCREEN_ROWS    = sxf_pkg::DEF_SCREEN_ROWS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  sxf_pkg::in_item_t  in_item_i,
  input  logic               q_pop_i,
  output sxf_pkg::cmdq_out_t q_o
);

  localparam logic [6:0] Cols = 7'(SCREEN_COLUMNS);
  localparam logic [6:0] Rows = 7'(SCREEN_ROWS);

  // modulo by compare-subtract of shifted modulus, quotient below 64
  function automatic logic [8:0] reduce(input logic [8:0] v, input logic [6:0] m);
    logic [8:0]  r;
    logic [14:0] step;
    r = v;
    for (int k = 5; k >= 0; k--) begin
      step = {8'd0, m} << k;
      if ({6'd0, r} >= step) begin
        r = r - step[8:0];
      end
    end
    return r;
  endfunction

  sxf_pkg::cmd_t     cmd;
  logic [8:0]        row_src;
  logic [8:0]        row_mod;
  logic [8:0]        x_mod;
  logic [6:0]        col;

  always_comb begin
    cmd = '0;
    unique case (in_item_i.req_type)
      sxf_pkg::REQ_CLEAR: cmd.op = sxf_pkg::OP_CLEAR;
      sxf_pkg::REQ_DRAW:  cmd.op = sxf_pkg::OP_DRAW;
      sxf_pkg::REQ_READ:  cmd.op = sxf_pkg::OP_READ;
      default:            cmd.op = sxf_pkg::OP_NOP;
    endcase
    cmd.new_sprite = (in_item_i.row_offset == 4'd0);

    // draw row wraps after adding the offset, read row is y alone
    if (cmd.op == sxf_pkg::OP_READ) begin
      row_src = {1'b0, in_item_i.y_pos};
    end else begin
      row_src = 9'(in_item_i.y_pos) + 9'(in_item_i.row_offset);
    end
    row_mod = reduce(row_src, Rows);
    cmd.row = row_mod[sxf_pkg::ROW_W-1:0];

    // sprite msb lands on the left column, columns wrap
    x_mod = reduce({1'b0, in_item_i.x_pos}, Cols);
    col   = '0;
    for (int i = 0; i < sxf_pkg::SPRITE_W; i++) begin
      col = {1'b0, x_mod[5:0]} + 7'(i);
      if (col >= Cols) begin
        col = col - Cols;
      end
      if (in_item_i.sprite_bits[3'(sxf_pkg::SPRITE_W - 1 - i)]) begin
        cmd.mask[col[5:0]] = 1'b1;
      end
    end
  end

  // two-entry command queue
  sxf_pkg::cmd_t slot_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;
  logic          do_push;
  logic          do_pop;

  assign full    = (count_q == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = q_pop_i && (count_q != 2'd0);

  assign q_o.avail = (count_q != 2'd0);
  assign q_o.cmd   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== hdl/sxf_back.sv =====
module sxf_back #(
  parameter int unsigned SCREEN_COLUMNS = sxf_pkg::DEF_SCREEN_COLUMNS,
  parameter int unsigned SCREEN_ROWS    = sxf_pkg::DEF_SCREEN_ROWS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sxf_pkg::cmdq_out_t q_i,
  output logic               q_pop_o,
  output logic               empty,
  input  logic               pop,
  output sxf_pkg::out_item_t out_item_o
);

  localparam int unsigned RowW = $clog2(SCREEN_ROWS);

  sxf_pkg::bk_state_e state_q, state_d;
  sxf_pkg::cmd_t      cmd_q;

  // frame store, one word per display row
  logic [SCREEN_COLUMNS-1:0] mem [SCREEN_ROWS];
  logic [SCREEN_COLUMNS-1:0] rd_q;
  logic                      rd_vld_q;
  logic [SCREEN_ROWS-1:0]    row_vld_q;

  logic [RowW-1:0]           rd_addr;
  logic [RowW-1:0]           wr_addr;
  logic                      mem_re, mem_we, clr_all;
  logic [SCREEN_COLUMNS-1:0] old_row, new_row, mask;
  logic                      hit;
  logic                      coll_q, coll_d;
  sxf_pkg::out_item_t        res;
  logic                      res_we;
  sxf_pkg::out_item_t        out_q;
  logic                      out_vld_q;

  assign rd_addr = q_i.cmd.row[RowW-1:0];
  assign wr_addr = cmd_q.row[RowW-1:0];
  assign mask    = cmd_q.mask[SCREEN_COLUMNS-1:0];
  assign old_row = rd_vld_q ? rd_q : '0;
  assign new_row = old_row ^ mask;
  assign hit     = |(old_row & mask);

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    mem_re  = 1'b0;
    mem_we  = 1'b0;
    clr_all = 1'b0;
    res_we  = 1'b0;
    coll_d  = coll_q;
    res     = '0;
    unique case (state_q)
      sxf_pkg::BK_IDLE: begin
        // start only when the result slot will be free
        if (q_i.avail && (!out_vld_q || pop)) begin
          q_pop_o = 1'b1;
          mem_re  = 1'b1;
          state_d = sxf_pkg::BK_EXEC;
        end
      end
      sxf_pkg::BK_EXEC: begin
        res_we = 1'b1;
        unique case (cmd_q.op)
          sxf_pkg::OP_CLEAR: clr_all = 1'b1;
          sxf_pkg::OP_DRAW: begin
            mem_we = 1'b1;
            coll_d = (cmd_q.new_sprite ? 1'b0 : coll_q) | hit;
          end
          sxf_pkg::OP_READ: res.row_pixels = sxf_pkg::PIX_W'(old_row);
          default: ;
        endcase
        res.collision = coll_d;
        state_d = sxf_pkg::BK_IDLE;
      end
      default: state_d = sxf_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= new_row;
    end
    if (mem_re) begin
      rd_q     <= mem[rd_addr];
      rd_vld_q <= row_vld_q[rd_addr];
      cmd_q    <= q_i.cmd;
    end
    if (res_we) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sxf_pkg::BK_IDLE;
      row_vld_q <= '0;
      coll_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      coll_q  <= coll_d;
      if (clr_all) begin
        row_vld_q <= '0;
      end else if (mem_we) begin
        row_vld_q[wr_addr] <= 1'b1;
      end
      if (res_we) begin
        out_vld_q <= 1'b1;
      end else if (pop && out_vld_q) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign empty      = !out_vld_q;
  assign out_item_o = out_q;

endmodule

// ===== hdl/sprite_xor_framebuffer_core.sv =====
// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+----------------------------------
// request   | in        | push / full              | in_item_i  (req, x, y, offset, bits)
// result    | out       | pop / empty              | out_item_o (collision, row pixels)
//
// each request takes a frame store read in the back-end idle state, then the
// xor/write and result capture in exec; no new command starts until exec ends
// a two-entry command queue decouples the front from the back end
// reset: no clearing pass, per-row valid bits make every row read as zero;
// a clear request drops all valid bits at once
// the back end waits while the result register is held and not popped
module sprite_xor_framebuffer_core #(
  parameter int unsigned SCREEN_COLUMNS = sxf_pkg::DEF_SCREEN_COLUMNS,
  parameter int unsigned SCREEN_ROWS    = sxf_pkg::DEF_SCREEN_ROWS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request side
  input  logic               push,
  output logic               full,
  input  sxf_pkg::in_item_t  in_item_i,
  // result side
  output logic               empty,
  input  logic               pop,
  output sxf_pkg::out_item_t out_item_o
);

  // command queue head and pop between front and back end
  sxf_pkg::cmdq_out_t q_head;
  logic               q_pop;

  // front: wraps coordinates, builds the 64-bit sprite mask, queues the command
  sxf_front #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .in_item_i(in_item_i),
    .q_pop_i  (q_pop),
    .q_o      (q_head)
  );

  // back: read-modify-write of the frame store, collision flag, result register
  sxf_back #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_i       (q_head),
    .q_pop_o   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item_o)
  );

endmodule

// ===== hdl/sxf_checker.sv =====
module sxf_checker #(
  parameter int unsigned SCREEN_COLUMNS = sxf_pkg::DEF_SCREEN_COLUMNS
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input sxf_pkg::out_item_t out_item_o
);

  // items accepted but not yet transferred out
  logic [2:0] pending_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 3'd0;
    end else begin
      pending_q <= pending_q + 3'(in_xfer) - 3'(out_xfer);
    end
  end

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("result changed or vanished while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pending_q != 3'd0))
    else $error("result shown with no item pending");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q <= 3'd4) && (!full || pending_q >= 3'd2))
    else $error("pending count out of range for queue and result stages");

  a_row_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((out_item_o.row_pixels >> SCREEN_COLUMNS) == '0))
    else $error("row pixels set beyond the screen width");

endmodule

bind sprite_xor_framebuffer_core sxf_checker #(
  .SCREEN_COLUMNS(SCREEN_COLUMNS)
) u_sxf_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .push      (push),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_item_o(out_item_o)
);

// ===== tb/sxf_frame_checker.sv =====
module sxf_frame_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  sxf_pkg::in_item_t  req_item_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  sxf_pkg::out_item_t rsp_item_i,
  output int unsigned        pending_o,
  output int unsigned        errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = sxf_pkg::DEF_SCREEN_COLUMNS;
  localparam int ROWS = sxf_pkg::DEF_SCREEN_ROWS;

  logic [sxf_pkg::PIX_W-1:0] shadow_rows [ROWS];
  logic                      shadow_hit;
  sxf_pkg::out_item_t        expected_results [$];
  int unsigned               mismatch_cnt;

  function automatic logic [sxf_pkg::PIX_W-1:0] sprite_mask(
    int x, logic [sxf_pkg::SPRITE_W-1:0] bits);
    logic [sxf_pkg::PIX_W-1:0] m;
    m = '0;
    for (int i = 0; i < sxf_pkg::SPRITE_W; i++) begin
      if (bits[sxf_pkg::SPRITE_W-1-i]) m[(x + i) % COLS] = 1'b1;
    end
    return m;
  endfunction

  // updates the shadow frame store and returns the result of one request
  function automatic sxf_pkg::out_item_t frame_request(sxf_pkg::in_item_t rq);
    sxf_pkg::out_item_t        res;
    int                        row;
    logic [sxf_pkg::PIX_W-1:0] m;
    res = '0;
    case (rq.req_type)
      sxf_pkg::REQ_CLEAR: begin
        for (int r = 0; r < ROWS; r++) shadow_rows[r] = '0;
      end
      sxf_pkg::REQ_DRAW: begin
        if (rq.row_offset == 0) shadow_hit = 1'b0;
        row = (int'(rq.y_pos) + int'(rq.row_offset)) % ROWS;
        m   = sprite_mask(int'(rq.x_pos) % COLS, rq.sprite_bits);
        if ((shadow_rows[row] & m) != '0) shadow_hit = 1'b1;
        shadow_rows[row] ^= m;
      end
      sxf_pkg::REQ_READ: begin
        res.row_pixels = shadow_rows[int'(rq.y_pos) % ROWS];
      end
      default: ;
    endcase
    res.collision = shadow_hit;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sxf_pkg::out_item_t want;
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) shadow_rows[r] = '0;
      shadow_hit = 1'b0;
      expected_results.delete();
      mismatch_cnt = 0;
    end else begin
      if (push_i && !full_i) expected_results.push_back(frame_request(req_item_i));
      if (pop_i && !empty_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatch_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (rsp_item_i.collision !== want.collision) begin
            $error("collision: expected %0d, actual %0d", want.collision,
                   rsp_item_i.collision);
            mismatch_cnt++;
          end
          if (rsp_item_i.row_pixels !== want.row_pixels) begin
            $error("row_pixels: expected %h, actual %h", want.row_pixels,
                   rsp_item_i.row_pixels);
            mismatch_cnt++;
          end
        end
      end
    end
    pending_o <= $unsigned(expected_results.size());
    errors_o  <= mismatch_cnt;
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // request code the block leaves unused
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // cycles without any transfer before the run is given up
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1750;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               push   = 1'b0;
  logic               full;
  sxf_pkg::in_item_t  req_item = '0;
  logic               empty;
  logic               pop    = 1'b0;
  sxf_pkg::out_item_t rsp_item;
  int unsigned        pending_cnt;
  int unsigned        error_cnt;
  int                 stall_cycles;
  int                 sent_cnt;
  // set while neither side may idle
  logic               steady = 1'b0;

  sprite_xor_framebuffer_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (req_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (rsp_item)
  );

  sxf_frame_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_i     (full),
    .req_item_i (req_item),
    .empty_i    (empty),
    .pop_i      (pop),
    .rsp_item_i (rsp_item),
    .pending_o  (pending_cnt),
    .errors_o   (error_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: pop is redrawn every falling edge, held low with a chance of 27 in 100 unless steady
  initial begin
    forever begin
      @(negedge clk_i);
      pop <= rst_ni && (steady || $urandom_range(99) >= 27);
    end
  end

  // watchdog on cycles in which neither side makes a transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT - 1) begin
        $display("FAIL sprite_xor_framebuffer_core");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end else begin
      stall_cycles <= 0;
    end
  end

  function automatic sxf_pkg::in_item_t pack_req(logic [1:0] kind, logic [7:0] x,
                                                 logic [7:0] y, logic [3:0] off,
                                                 logic [7:0] bits);
    sxf_pkg::in_item_t it;
    it.req_type    = kind;
    it.x_pos       = x;
    it.y_pos       = y;
    it.row_offset  = off;
    it.sprite_bits = bits;
    return it;
  endfunction

  // entered and left at a falling edge; holds push until the transfer happens
  task automatic send_req(sxf_pkg::in_item_t it);
    while (!steady && $urandom_range(99) < 27) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push     <= 1'b1;
    req_item <= it;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
    sent_cnt++;
  endtask

  // one whole sprite with rows at offsets 0..n-1, reads sometimes mixed in
  task automatic draw_sprite();
    logic [7:0] x, y;
    int         height;
    x      = 8'($urandom);
    y      = 8'($urandom);
    height = $urandom_range(1, 16);
    for (int r = 0; r < height; r++) begin
      send_req(pack_req(sxf_pkg::REQ_DRAW, x, y, 4'(r), 8'($urandom)));
      if ($urandom_range(99) < 10)
        send_req(pack_req(sxf_pkg::REQ_READ, 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom)));
    end
  endtask

  initial begin
    int pick;
    sent_cnt = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extremes, wrap-around, collision handling, unused code
    send_req(pack_req(sxf_pkg::REQ_CLEAR, 8'h00, 8'h00, 4'h0, 8'h00));
    send_req(pack_req(sxf_pkg::REQ_READ, 8'h00, 8'hff, 4'h0, 8'h00));
    send_req(pack_req(sxf_pkg::REQ_DRAW, 8'h00, 8'h00, 4'h0, 8'h80));
    send_req(pack_req(sxf_pkg::REQ_READ, 8'h00, 8'h00, 4'h0, 8'h00));
    // columns wrap from 63 back to 0, row 31
    send_req(pack_req(sxf_pkg::REQ_DRAW, 8'h3f, 8'h1f, 4'h0, 8'hff));
    send_req(pack_req(sxf_pkg::REQ_READ, 8'h00, 8'h1f, 4'h0, 8'h00));
    // row (255 + 15) mod 32, column 255 mod 64
    send_req(pack_req(sxf_pkg::REQ_DRAW, 8'hff, 8'hff, 4'hf, 8'haa));
    send_req(pack_req(sxf_pkg::REQ_READ, 8'hff, 8'h0e, 4'hf, 8'hff));
    // erase a lit pixel through a wrapped row: collision set
    send_req(pack_req(sxf_pkg::REQ_DRAW, 8'h40, 8'h20, 4'h1, 8'h00));
    send_req(pack_req(sxf_pkg::REQ_DRAW, 8'h00, 8'h20, 4'h0, 8'h80));
    // later rows keep the flag
    send_req(pack_req(sxf_pkg::REQ_DRAW, 8'hc8, 8'h11, 4'hf, 8'h55));
    send_req(pack_req(sxf_pkg::REQ_DRAW, 8'hc8, 8'h11, 4'h7, 8'h00));
    // unused code leaves everything alone
    send_req(pack_req(REQ_UNUSED, 8'hff, 8'hff, 4'hf, 8'hff));
    send_req(pack_req(REQ_UNUSED, 8'h00, 8'h00, 4'h0, 8'h00));
    // clear and read keep the flag
    send_req(pack_req(sxf_pkg::REQ_CLEAR, 8'hff, 8'hff, 4'hf, 8'hff));
    send_req(pack_req(sxf_pkg::REQ_READ, 8'h00, 8'h00, 4'h0, 8'h00));
    // new sprite clears the flag even with no pixels
    send_req(pack_req(sxf_pkg::REQ_DRAW, 8'h00, 8'h00, 4'h0, 8'h00));
    send_req(pack_req(sxf_pkg::REQ_DRAW, 8'h38, 8'h00, 4'h0, 8'hff));
    send_req(pack_req(sxf_pkg::REQ_DRAW, 8'h38, 8'h00, 4'h1, 8'hff));
    send_req(pack_req(sxf_pkg::REQ_READ, 8'h00, 8'h00, 4'h0, 8'h00));
    send_req(pack_req(sxf_pkg::REQ_READ, 8'h00, 8'h01, 4'h0, 8'h00));
    // same row again: everything erased, collision
    send_req(pack_req(sxf_pkg::REQ_DRAW, 8'h78, 8'h40, 4'h1, 8'hff));
    send_req(pack_req(sxf_pkg::REQ_READ, 8'h00, 8'h21, 4'h0, 8'h00));

    // random: mostly whole sprites on a filling screen, with stray requests mixed in
    while (sent_cnt < RANDOM_ITEMS) begin
      steady <= (sent_cnt >= 700 && sent_cnt < 1000);
      pick = $urandom_range(99);
      if (pick < 1)
        send_req(pack_req(sxf_pkg::REQ_CLEAR, 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom)));
      else if (pick < 4)
        send_req(pack_req(REQ_UNUSED, 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom)));
      else if (pick < 25)
        send_req(pack_req(sxf_pkg::REQ_READ, 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom)));
      else if (pick < 35)
        send_req(pack_req(sxf_pkg::REQ_DRAW, 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom)));
      else
        draw_sprite();
    end
    push   <= 1'b0;
    steady <= 1'b0;

    // drain, then keep waiting for any stray result before the verdict
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_cnt == 0 && pending_cnt == 0) begin
      $display("PASS sprite_xor_framebuffer_core");
    end else begin
      $display("FAIL sprite_xor_framebuffer_core");
    end
    $finish;
  end

endmodule

// ===== sprite_xor_framebuffer_core.f =====
hdl/sxf_pkg.sv
hdl/sxf_front.sv
hdl/sxf_back.sv
hdl/sprite_xor_framebuffer_core.sv
hdl/sxf_checker.sv
tb/sxf_frame_checker.sv
tb/tb.sv
